### rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// Console line editor package
// Shared constants, command codes, queue entry type and echo helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

   // Default number of entries in the line store.
   localparam int LINE_DEPTH_DEFAULT = 128;

   // Entries in the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // Command codes carried in the request tuser.
   localparam logic [1:0] CMD_RECEIVE = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SP    = 8'd32;
   localparam logic [7:0] CH_DEL   = 8'd127;
   localparam logic [7:0] PRINT_LO = 8'd32;
   localparam logic [7:0] PRINT_HI = 8'd126;

   // What a classified item echoes.
   typedef enum logic [1:0] {
      ECHO_NONE,
      ECHO_CHAR,
      ECHO_RUBOUT,
      ECHO_CRLF
   } echo_kind_type;

   // One classified item, as handed from the front to the back.
   typedef struct packed {
      echo_kind_type kind;
      logic [7:0]    echo_char;
      logic          line_ready;
      logic [6:0]    line_length;
      logic [7:0]    read_data;
   } queue_entry_type;

   // Index of the final result that an item of this kind produces.
   function automatic logic [1:0] last_step(input echo_kind_type kind);
      logic [1:0] step;
      unique case (kind)
         ECHO_NONE:   step = 2'd0;
         ECHO_CHAR:   step = 2'd0;
         ECHO_RUBOUT: step = 2'd2;
         ECHO_CRLF:   step = 2'd1;
      endcase
      return step;
   endfunction

   // Echo byte for a given kind at a given result step.
   function automatic logic [7:0] echo_value(input echo_kind_type kind,
                                             input logic [7:0] ch,
                                             input logic [1:0] step);
      logic [7:0] value;
      unique case (kind)
         ECHO_NONE:   value = 8'd0;
         ECHO_CHAR:   value = ch;
         ECHO_RUBOUT: value = (step == 2'd1) ? CH_SP : CH_BS;
         ECHO_CRLF:   value = (step == 2'd0) ? CH_CR : CH_LF;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

### rtl/console_line_editor_top.sv
// ----------------------------------------------------------------------------
// Console line editor
// Edits a command line from received serial bytes and produces echo bytes.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one command per item: cmd in req_tuser, rx_byte and
// read_index in req_tdata. A receive command edits the line, a read command
// returns a stored character, a release command clears a finished line.
// The rsp channel gives one result item per echoed byte (up to three for a
// rubout), or one result with echo_valid low; rsp_tlast marks the final
// result of each command. Every result also shows the line-ready flag and
// the line length after the command.
// The first result of an item passes the stage register, the four-entry
// queue and the output register. Throughput: one item per cycle while each
// item gives one result and rsp_tready is high; an item with several results
// holds the output register until its last result is loaded, and the queue
// lets the front keep accepting meanwhile. The output register sets the rate.
// Reset clears the line length and the line-ready flag; the line store is
// not cleared and needs no clearing pass. When rsp_tready is low, results
// hold in the output register, the queue fills, and then req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_editor_top #(
   parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // rx_byte[7:0], read_index[14:8], zero
   input  wire logic [1:0]  req_tuser,   // cmd[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // echo_byte[7:0], line_ready[8],
                                         // line_length[15:9], read_data[23:16]
   output logic [0:0]       rsp_tuser,   // echo_valid[0]
   output logic             rsp_tlast
);

   logic                     push_valid;
   logic                     push_ready;
   cle_pkg::queue_entry_type push_entry;
   logic                     pop_valid;
   logic                     pop_ready;
   cle_pkg::queue_entry_type pop_entry;

   // Front: accept, classify, keep line state and store.
   cle_front #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Queue between the two sides.
   cle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Back: expand entries into result items.
   cle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

### rtl/cle_front.sv
// ----------------------------------------------------------------------------
// Console line editor front
// Accepts request items, classifies them, keeps the line state and the line
// store, and hands one classified entry per item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_front #(
   parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [1:0]               req_tuser,   // cmd
   input  wire logic [15:0]              req_tdata,   // rx_byte, read_index
   output logic                          push_valid,
   input  wire logic                     push_ready,
   output cle_pkg::queue_entry_type      push_entry
);

   localparam int AddrWidth = $clog2(LINE_DEPTH);
   localparam int CmpWidth  = (AddrWidth > 7) ? AddrWidth : 7;
   localparam logic [AddrWidth-1:0] CountMax = AddrWidth'(LINE_DEPTH - 1);

   logic [1:0]             cmd;
   logic [7:0]             rx_byte;
   logic [6:0]             read_index;
   logic                   accept;

   logic [AddrWidth-1:0]   count_ff, count_in, count_upd;
   logic                   done_ff, done_in, done_upd;

   cle_pkg::echo_kind_type kind;
   logic                   wr_en;
   logic                   rd_hit;

   logic                   stage_valid_ff, stage_valid_in;
   cle_pkg::echo_kind_type stage_kind_ff;
   logic [7:0]             stage_char_ff;
   logic                   stage_hit_ff;
   logic                   stage_ready_ff;
   logic [6:0]             stage_length_ff;

   logic [7:0]             line_mem [LINE_DEPTH];
   logic [7:0]             read_ff;

   assign cmd        = req_tuser;
   assign rx_byte    = req_tdata[7:0];
   assign read_index = req_tdata[14:8];

   // The stage register frees up when its entry moves into the queue.
   assign req_tready = !stage_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;

   // Classify the item against the current line state.
   always_comb begin
      kind      = cle_pkg::ECHO_NONE;
      wr_en     = 1'b0;
      rd_hit    = 1'b0;
      count_upd = count_ff;
      done_upd  = done_ff;
      unique case (cmd)
         cle_pkg::CMD_RECEIVE: begin
            if (!done_ff) begin
               if (rx_byte == cle_pkg::CH_CR || rx_byte == cle_pkg::CH_LF) begin
                  if (count_ff != '0) begin
                     kind     = cle_pkg::ECHO_CRLF;
                     done_upd = 1'b1;
                  end
               end else if (rx_byte == cle_pkg::CH_BS || rx_byte == cle_pkg::CH_DEL) begin
                  if (count_ff != '0) begin
                     kind      = cle_pkg::ECHO_RUBOUT;
                     count_upd = count_ff - 1'b1;
                  end
               end else if (rx_byte >= cle_pkg::PRINT_LO && rx_byte <= cle_pkg::PRINT_HI) begin
                  if (count_ff != CountMax) begin
                     kind      = cle_pkg::ECHO_CHAR;
                     wr_en     = 1'b1;
                     count_upd = count_ff + 1'b1;
                  end
               end
            end
         end
         cle_pkg::CMD_READ: begin
            rd_hit = CmpWidth'(read_index) < CmpWidth'(count_ff);
         end
         cle_pkg::CMD_RELEASE: begin
            if (done_ff) begin
               count_upd = '0;
               done_upd  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Line state moves only on an accepted item.
   assign count_in = accept ? count_upd : count_ff;
   assign done_in  = accept ? done_upd : done_ff;

   assign stage_valid_in = accept ? 1'b1 : (push_ready ? 1'b0 : stage_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         done_ff        <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         done_ff        <= done_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Stage payload, loaded with the item.
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_kind_ff   <= kind;
         stage_char_ff   <= rx_byte;
         stage_hit_ff    <= rd_hit;
         stage_ready_ff  <= done_in;
         stage_length_ff <= 7'(count_in);
      end
   end

   // Line store: written at the current count, read at the requested index.
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         line_mem[count_ff] <= rx_byte;
      end
      if (accept && rd_hit) begin
         read_ff <= line_mem[AddrWidth'(read_index)];
      end
   end

   // Entry handed to the queue.
   assign push_valid             = stage_valid_ff;
   assign push_entry.kind        = stage_kind_ff;
   assign push_entry.echo_char   = stage_char_ff;
   assign push_entry.line_ready  = stage_ready_ff;
   assign push_entry.line_length = stage_length_ff;
   assign push_entry.read_data   = stage_hit_ff ? read_ff : 8'd0;

endmodule

`default_nettype wire

### rtl/cle_queue.sv
// ----------------------------------------------------------------------------
// Console line editor queue
// Short first-in first-out buffer of classified entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   output logic                          push_ready,
   input  wire cle_pkg::queue_entry_type push_entry,
   output logic                          pop_valid,
   input  wire logic                     pop_ready,
   output cle_pkg::queue_entry_type      pop_entry
);

   localparam int PtrWidth   = $clog2(cle_pkg::QUEUE_DEPTH);
   localparam int CountWidth = $clog2(cle_pkg::QUEUE_DEPTH + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(cle_pkg::QUEUE_DEPTH);

   cle_pkg::queue_entry_type entry_ff [cle_pkg::QUEUE_DEPTH];
   logic [PtrWidth-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]    fill_ff, fill_in;
   logic                     push;
   logic                     pop;

   assign push_ready = (fill_ff != CountFull);
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = entry_ff[rd_ptr_ff];

   // Pointer and fill updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### rtl/cle_back.sv
// ----------------------------------------------------------------------------
// Console line editor back
// Expands each queued entry into its one to three result items and holds
// them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     pop_valid,
   output logic                          pop_ready,
   input  wire cle_pkg::queue_entry_type pop_entry,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [23:0]                   rsp_tdata,   // echo_byte, line_ready,
                                                      // line_length, read_data
   output logic [0:0]                    rsp_tuser,   // echo_valid
   output logic                          rsp_tlast
);

   logic [1:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;
   logic        rsp_user_ff;
   logic        rsp_last_ff;
   logic        load;
   logic        final_step;

   // A new result enters the output register when it is empty or being taken.
   assign load       = pop_valid && (!rsp_valid_ff || rsp_tready);
   assign final_step = (step_ff == cle_pkg::last_step(pop_entry.kind));
   assign pop_ready  = load && final_step;

   assign step_in      = load ? (final_step ? 2'd0 : step_ff + 2'd1) : step_ff;
   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload for the current step of the head entry.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_user_ff <= (pop_entry.kind != cle_pkg::ECHO_NONE);
         rsp_data_ff <= {pop_entry.read_data,
                         pop_entry.line_length,
                         pop_entry.line_ready,
                         cle_pkg::echo_value(pop_entry.kind, pop_entry.echo_char, step_ff)};
         rsp_last_ff <= final_step;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;
   assign rsp_tlast    = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/cle_checker.sv
// ----------------------------------------------------------------------------
// Console line editor checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A result without echo is a single, final result with a zero echo byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("non-echo result malformed");

   // Echo results never carry read data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[23:16] == 8'd0))
      else $error("echo result carries read data");

   // Line-ready results have a non-empty line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> (rsp_tdata[15:9] != 7'd0))
      else $error("line ready with empty line");

   // No result directly after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind console_line_editor_top cle_checker u_cle_checker (.*);

`default_nettype wire
